/* design/cdte_pkg.sv */
package cdte_pkg;

  // Payload widths
  localparam int unsigned NumW   = 16;
  localparam int unsigned EpochW = 26;
  localparam int unsigned YdayW  = 18;
  localparam int unsigned WdayW  = 3;

  // Pipeline depth from input register to output register
  localparam int unsigned Depth = 6;

  // Calendar constants
  localparam logic [NumW-1:0] IsoYearMin  = 16'd1900;
  localparam logic [NumW-1:0] IsoMonthMax = 16'd12;
  localparam logic [NumW-1:0] IsoDayMax   = 16'd31;
  localparam logic [16:0]     CycleShift  = 17'd400;
  localparam logic [8:0]      YearsCycle  = 9'd400;
  localparam logic [8:0]      DaysYear    = 9'd365;
  localparam logic [17:0]     DaysCycle   = 18'd146097;

  // Offset from day zero of year zero (shifted one cycle) to 1970-01-01, minus one for day
  localparam logic [EpochW-1:0] EpochBias = 26'd865566;

  // Reciprocal of 25 for values below 4682, shift 15
  localparam logic [10:0] Recip25 = 11'd1311;
  localparam int unsigned Shift25 = 15;

  // Reciprocal of 7 for values below 2^18, shift 24
  localparam logic [21:0] Recip7 = 22'd2396746;
  localparam int unsigned Shift7 = 24;

  // Weekday offset: 1970-01-01 was a Thursday, folded with the day bias mod 7
  localparam logic [17:0] WdayBias = 18'd2;

  // Days in the months before month m of a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Days from March 1 to the first of month m in a March-based year
  function automatic logic [8:0] march_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/cdte_if.sv */
interface cdte_in_if;
  import cdte_pkg::*;

  logic            valid;
  logic            ready;
  logic [NumW-1:0] first_number;
  logic [NumW-1:0] second_number;
  logic [NumW-1:0] third_number;

  modport source (output valid, first_number, second_number, third_number, input ready);
  modport sink   (input valid, first_number, second_number, third_number, output ready);
endinterface

interface cdte_out_if;
  import cdte_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [EpochW-1:0] epoch_days;
  logic signed [YdayW-1:0]  year_day;
  logic [WdayW-1:0]         week_day;
  logic                     month_error;

  modport source (output valid, epoch_days, year_day, week_day, month_error, input ready);
  modport sink   (input valid, epoch_days, year_day, week_day, month_error, output ready);
endinterface

/* design/civil_date_to_epoch_days_top.sv */
// Civil date to day count since 1970-01-01, proleptic Gregorian calendar.
// Input channel date_i: three 16-bit numbers per request. When the first is
// at least 1900, the second at most 12 and the third at most 31 they are
// year, month, day; otherwise month, day, year.
// Output channel result_o: signed day count, zero-based day of year, weekday
// (0 is Sunday) and a month error flag; on a month outside 1..12 the other
// fields are zero.
// Six register stages, the first loaded at the accepting edge. Throughput: one
// request per cycle unless a receiver stall fills the pipeline; the stages take
// ordering and month check, era split, year of era and month tables, day of era
// with era scaling, epoch sum, and the weekday multiply.
// Each stage holds a valid bit and loads when it is empty or the stage after
// it moves, so bubbles are squeezed out and date_i.ready stays high while
// any stage has room.
// When the receiver stalls, the result holds steady and the pipeline fills
// up; date_i.ready drops once all six stages hold a request.
// Reset empties all stages; date_i.ready is high right after reset.
module civil_date_to_epoch_days_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdte_in_if.sink    date_i,
  cdte_out_if.source result_o
);
  import cdte_pkg::*;

  // Stage valid bits and enables
  logic [Depth:1] valid_q;
  logic [Depth+1:1] en;

  always_comb begin
    en[Depth+1] = result_o.ready;
    for (int k = Depth; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign date_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) valid_q[1] <= date_i.valid;
      for (int k = 2; k <= Depth; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Stage 1: resolve ordering, check month, shift year
  logic        iso;
  logic [15:0] year, month, day;
  logic        bad_month;
  logic [16:0] yy_d;
  logic [16:0] s1_yy_q;
  logic [3:0]  s1_m_q;
  logic [15:0] s1_d_q;
  logic        s1_err_q;

  always_comb begin
    iso = (date_i.first_number >= IsoYearMin) && (date_i.second_number <= IsoMonthMax) &&
          (date_i.third_number <= IsoDayMax);
    if (iso) begin
      year  = date_i.first_number;
      month = date_i.second_number;
      day   = date_i.third_number;
    end else begin
      month = date_i.first_number;
      day   = date_i.second_number;
      year  = date_i.third_number;
    end
    bad_month = (month == 16'd0) || (month > IsoMonthMax);
    yy_d      = {1'b0, year} + CycleShift - ((month <= 16'd2) ? 17'd1 : 17'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_yy_q  <= yy_d;
      s1_m_q   <= month[3:0];
      s1_d_q   <= day;
      s1_err_q <= bad_month;
    end
  end

  // Stage 2: era number by shift and reciprocal of 25
  logic [23:0] era_prod;
  logic [7:0]  s2_era_q;
  logic [16:0] s2_yy_q;
  logic [3:0]  s2_m_q;
  logic [15:0] s2_d_q;
  logic        s2_err_q;

  assign era_prod = {11'd0, s1_yy_q[16:4]} * {13'd0, Recip25};

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_era_q <= era_prod[Shift25 +: 8];
      s2_yy_q  <= s1_yy_q;
      s2_m_q   <= s1_m_q;
      s2_d_q   <= s1_d_q;
      s2_err_q <= s1_err_q;
    end
  end

  // Stage 3: year of era, century count, leap flag, month tables
  logic [16:0] yoe_full;
  logic [8:0]  yoe;
  logic [1:0]  cent;
  logic        leap;
  logic [8:0]  s3_yoe_q;
  logic [1:0]  s3_cent_q;
  logic [7:0]  s3_era_q;
  logic [8:0]  s3_mdays_q;
  logic [8:0]  s3_cum_q;
  logic        s3_adj_q;
  logic [15:0] s3_d_q;
  logic        s3_err_q;

  always_comb begin
    yoe_full = s2_yy_q - ({9'd0, s2_era_q} * {8'd0, YearsCycle});
    yoe      = yoe_full[8:0];
    if (yoe >= 9'd300)      cent = 2'd3;
    else if (yoe >= 9'd200) cent = 2'd2;
    else if (yoe >= 9'd100) cent = 2'd1;
    else                    cent = 2'd0;
    // Year of era equals year mod 400 after February
    leap = (yoe[1:0] == 2'd0) && (yoe != 9'd100) && (yoe != 9'd200) && (yoe != 9'd300);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_yoe_q   <= yoe;
      s3_cent_q  <= cent;
      s3_era_q   <= s2_era_q;
      s3_mdays_q <= march_days(s2_m_q);
      s3_cum_q   <= cum_days(s2_m_q);
      s3_adj_q   <= leap && (s2_m_q > 4'd2);
      s3_d_q     <= s2_d_q;
      s3_err_q   <= s2_err_q;
    end
  end

  // Stage 4: day of era, era days, day of year
  logic [17:0] doe_d;
  logic [24:0] era_days_d;
  logic [17:0] yday_d;
  logic [17:0] s4_doe_q;
  logic [24:0] s4_era_days_q;
  logic [17:0] s4_yday_q;
  logic [15:0] s4_d_q;
  logic        s4_err_q;

  always_comb begin
    doe_d = ({9'd0, s3_yoe_q} * {9'd0, DaysYear}) + {11'd0, s3_yoe_q[8:2]} -
            {16'd0, s3_cent_q} + {9'd0, s3_mdays_q};
    era_days_d = {17'd0, s3_era_q} * {7'd0, DaysCycle};
    yday_d = {2'd0, s3_d_q} + {9'd0, s3_cum_q} + {17'd0, s3_adj_q} - 18'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_doe_q      <= doe_d;
      s4_era_days_q <= era_days_d;
      s4_yday_q     <= yday_d;
      s4_d_q        <= s3_d_q;
      s4_err_q      <= s3_err_q;
    end
  end

  // Stage 5: epoch days and weekday argument; zero fields on a bad month
  logic [EpochW-1:0] days_d;
  logic [17:0]       wx_d;
  logic [EpochW-1:0] s5_days_q;
  logic [YdayW-1:0]  s5_yday_q;
  logic              s5_err_q;

  always_comb begin
    days_d = {1'b0, s4_era_days_q} + {8'd0, s4_doe_q} + {10'd0, s4_d_q} - EpochBias;
    wx_d   = s4_err_q ? 18'd0 : (s4_doe_q + {2'd0, s4_d_q} + WdayBias);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_days_q <= s4_err_q ? '0 : days_d;
      s5_yday_q <= s4_err_q ? '0 : s4_yday_q;
      s5_err_q  <= s4_err_q;
    end
  end

  // Stage 6: weekday by reciprocal multiply, result register
  logic [EpochW-1:0] s6_days_q;
  logic [YdayW-1:0]  s6_yday_q;
  logic              s6_err_q;
  logic [WdayW-1:0]  wd;
  logic [17:0]       s5_wx_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_wx_q <= wx_d;
    end
  end

  cdte_wday u_wday (
    .clk_i (clk_i),
    .en_i  (en[6]),
    .x_i   (s5_wx_q),
    .wd_o  (wd)
  );

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_days_q <= s5_days_q;
      s6_yday_q <= s5_yday_q;
      s6_err_q  <= s5_err_q;
    end
  end

  assign result_o.valid       = valid_q[Depth];
  assign result_o.epoch_days  = s6_days_q;
  assign result_o.year_day    = s6_yday_q;
  assign result_o.week_day    = wd;
  assign result_o.month_error = s6_err_q;

endmodule

/* design/cdte_wday.sv */
module cdte_wday (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [17:0]               x_i,
  output logic [cdte_pkg::WdayW-1:0] wd_o
);
  import cdte_pkg::*;

  logic [39:0] prod;
  logic [15:0] quot_d, quot_q;
  logic [17:0] x_q;
  logic [17:0] rem;

  // Quotient by 7 through the reciprocal, registered
  assign prod   = {22'd0, x_i} * {18'd0, Recip7};
  assign quot_d = prod[Shift7 +: 16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
      x_q    <= x_i;
    end
  end

  // Remainder from the stored quotient
  assign rem  = x_q - ({2'd0, quot_q} * 18'd7);
  assign wd_o = rem[WdayW-1:0];

endmodule

/* design/cdte_checker.sv */
module cdte_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [cdte_pkg::EpochW-1:0] epoch_days_i,
  input logic signed [cdte_pkg::YdayW-1:0]  year_day_i,
  input logic [cdte_pkg::WdayW-1:0]         week_day_i,
  input logic                            month_error_i
);
  import cdte_pkg::*;

  // Track requests inside the block
  logic [3:0] inflight_d, inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    inflight_d = inflight_q + {3'd0, in_acc} - {3'd0, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(epoch_days_i) &&
    $stable(year_day_i) && $stable(week_day_i) && $stable(month_error_i))
    else $error("result changed while stalled");

  // No result without a request inside
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 4'd0)
    else $error("result without a pending request");

  // Never more requests inside than stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 4'(Depth))
    else $error("more requests in flight than stages");

  // A bad month zeroes the other fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && month_error_i |->
    epoch_days_i == '0 && year_day_i == '0 && week_day_i == '0)
    else $error("fields not zero on month error");

  // Weekday stays in range
  a_wday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> week_day_i <= 3'd6)
    else $error("weekday out of range");

endmodule

bind civil_date_to_epoch_days_top cdte_checker u_cdte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (date_i.valid),
  .in_ready_i    (date_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .epoch_days_i  (result_o.epoch_days),
  .year_day_i    (result_o.year_day),
  .week_day_i    (result_o.week_day),
  .month_error_i (result_o.month_error)
);

/* sim/tb_civil_date_to_epoch_days_top.sv */
module tb_civil_date_to_epoch_days_top;
  import cdte_pkg::*;

  // Days from 0000-01-01 to 1970-01-01, proleptic Gregorian
  localparam longint      EpochOffset = 719528;
  localparam int unsigned LongHold    = 60;
  localparam int unsigned BurstLen    = 30;
  localparam int unsigned RandomDates = 1280;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct packed {
    logic signed [EpochW-1:0] epoch_days;
    logic signed [YdayW-1:0]  year_day;
    logic [WdayW-1:0]         week_day;
    logic                     month_error;
  } day_count_t;

  typedef struct packed {
    logic [NumW-1:0] first_num;
    logic [NumW-1:0] second_num;
    logic [NumW-1:0] third_num;
    logic            typed;
    day_count_t      want;
  } date_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cdte_in_if  date_if ();
  cdte_out_if result_if ();

  civil_date_to_epoch_days_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .date_i   (date_if),
    .result_o (result_if)
  );

  always #1 clk_i = ~clk_i;

  day_count_t  expected_days [$];
  date_row_t   dir_rows [$];
  day_count_t  next_due;
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned dates_sent      = 0;
  int unsigned iso_dates       = 0;
  int unsigned error_dates     = 0;
  int unsigned cycle_count     = 0;
  bit          tx_calm         = 1'b0;
  bit          rx_calm         = 1'b0;
  bit          hold_off_req    = 1'b0;

  // Work out day count, day of year and weekday for one request
  function automatic day_count_t predict_day_count(input logic [NumW-1:0] a,
                                                   input logic [NumW-1:0] b,
                                                   input logic [NumW-1:0] c);
    longint     yr, mon, dom, yday, days, wd;
    int         k;
    day_count_t r;
    r = '0;
    if (a >= IsoYearMin && b <= IsoMonthMax && c <= IsoDayMax) begin
      yr = longint'(a); mon = longint'(b); dom = longint'(c);
    end else begin
      mon = longint'(a); dom = longint'(b); yr = longint'(c);
    end
    if (mon < 1 || mon > 12) begin
      r.month_error = 1'b1;
      return r;
    end
    yday = dom - 1;
    for (k = 1; k < mon; k++) begin
      case (k)
        2:             yday += 28;
        4, 6, 9, 11:   yday += 30;
        default:       yday += 31;
      endcase
    end
    // Leap day counts only from March on
    if (mon > 2 && (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0)) yday += 1;
    // Leap years in 0..yr-1, year zero being leap
    days = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400
           - EpochOffset + yday;
    wd = (days + 4) % 7;
    if (wd < 0) wd += 7;
    r.epoch_days = days[EpochW-1:0];
    r.year_day   = yday[YdayW-1:0];
    r.week_day   = wd[WdayW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, results_checked, got, want);
    mismatches++;
  endtask

  task automatic add_row(input int unsigned a, input int unsigned b, input int unsigned c,
                         input bit typed, input longint epoch, input longint yday,
                         input int unsigned wday, input bit err);
    date_row_t row;
    row.first_num        = a[NumW-1:0];
    row.second_num       = b[NumW-1:0];
    row.third_num        = c[NumW-1:0];
    row.typed            = typed;
    row.want.epoch_days  = epoch[EpochW-1:0];
    row.want.year_day    = yday[YdayW-1:0];
    row.want.week_day    = wday[WdayW-1:0];
    row.want.month_error = err;
    dir_rows.push_back(row);
  endtask

  // Offer one request, hold it until accepted, then queue its expected result
  task automatic send_date(input logic [NumW-1:0] a, input logic [NumW-1:0] b,
                           input logic [NumW-1:0] c, input bit typed, input day_count_t want);
    int unsigned gap;
    day_count_t  exp_r;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      date_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    date_if.valid         <= 1'b1;
    date_if.first_number  <= a;
    date_if.second_number <= b;
    date_if.third_number  <= c;
    @(posedge clk_i);
    while (!date_if.ready) @(posedge clk_i);
    exp_r = typed ? want : predict_day_count(a, b, c);
    expected_days.push_back(exp_r);
    dates_sent++;
    if (a >= IsoYearMin && b <= IsoMonthMax && c <= IsoDayMax) iso_dates++;
    if (exp_r.month_error) error_dates++;
  endtask

  // Mostly well-formed dates in either order, some raw noise
  task automatic next_random_date(output logic [NumW-1:0] a, output logic [NumW-1:0] b,
                                  output logic [NumW-1:0] c);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      a = NumW'($urandom_range(1900, 65535));
      b = NumW'($urandom_range(0, 12));
      c = NumW'($urandom_range(0, 31));
    end else if (kind < 8) begin
      a = NumW'($urandom_range(0, 13));
      b = NumW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 31));
      c = NumW'($urandom);
    end else begin
      a = NumW'($urandom);
      b = NumW'($urandom);
      c = NumW'($urandom);
    end
  endtask

  // Drop the request line, hold until every queued result has come back,
  // then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    date_if.valid <= 1'b0;
    while (expected_days.size() != 0) @(posedge clk_i);
    repeat (Depth + 4) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off when requested
  initial begin
    int unsigned stall;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (hold_off_req) begin
        stall += LongHold;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_days.size() == 0) begin
        report_mismatch("result with none pending", longint'(result_if.epoch_days), 0);
      end else begin
        next_due = expected_days.pop_front();
        if (result_if.epoch_days !== next_due.epoch_days)
          report_mismatch("epoch_days", longint'(result_if.epoch_days),
                          longint'(next_due.epoch_days));
        if (result_if.year_day !== next_due.year_day)
          report_mismatch("year_day", longint'(result_if.year_day),
                          longint'(next_due.year_day));
        if (result_if.week_day !== next_due.week_day)
          report_mismatch("week_day", longint'(result_if.week_day),
                          longint'(next_due.week_day));
        if (result_if.month_error !== next_due.month_error)
          report_mismatch("month_error", longint'(result_if.month_error),
                          longint'(next_due.month_error));
      end
      results_checked++;
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_days.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [NumW-1:0] a, b, c;
    int unsigned     k;
    day_count_t      none;
    none = '0;
    date_if.valid         = 1'b0;
    date_if.first_number  = '0;
    date_if.second_number = '0;
    date_if.third_number  = '0;

    //      first  second  third  typed  epoch   yday  wday err
    add_row(1970,  1,      1,     1,     0,      0,    4,   0); // epoch, ISO order
    add_row(1,     1,      1970,  1,     0,      0,    4,   0); // epoch, US order
    add_row(12,    31,     1969,  1,     -1,     364,  3,   0);
    add_row(2000,  1,      1,     1,     10957,  0,    6,   0);
    add_row(0,     0,      0,     1,     0,      0,    0,   1); // month zero
    add_row(13,    1,      2000,  1,     0,      0,    0,   1); // month 13
    add_row(1900,  0,      5,     1,     0,      0,    0,   1); // ISO order, month zero
    add_row(1900,  13,     5,     1,     0,      0,    0,   1); // falls back, month 1900
    add_row(1899,  12,     31,    1,     0,      0,    0,   1); // year too low for ISO
    add_row(1900,  12,     32,    1,     0,      0,    0,   1); // day too high for ISO
    add_row(65535, 65535,  65535, 1,     0,      0,    0,   1); // all ones
    add_row(65535, 12,     31,    0,     0,      0,    0,   0); // latest ISO date
    add_row(1900,  12,     31,    0,     0,      0,    0,   0);
    add_row(12,    65535,  65535, 0,     0,      0,    0,   0); // largest count
    add_row(1,     0,      0,     0,     0,      0,    0,   0); // day zero of year zero
    add_row(2,     29,     0,     0,     0,      0,    0,   0); // year zero is leap
    add_row(3,     1,      0,     0,     0,      0,    0,   0);
    add_row(2000,  2,      29,    0,     0,      0,    0,   0);
    add_row(2000,  3,      1,     0,     0,      0,    0,   0);
    add_row(1900,  3,      1,     0,     0,      0,    0,   0); // century, not leap
    add_row(2,     30,     2023,  0,     0,      0,    0,   0); // day past month end
    add_row(2024,  12,     31,    0,     0,      0,    0,   0);
    add_row(3000,  12,     31,    0,     0,      0,    0,   0);
    add_row(3001,  1,      1,     0,     0,      0,    0,   0);
    add_row(12,    0,      100,   0,     0,      0,    0,   0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (dir_rows[i])
      send_date(dir_rows[i].first_num, dir_rows[i].second_num, dir_rows[i].third_num,
                dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // Back-to-back requests against a long receiver hold-off
    tx_calm      = 1'b1;
    rx_calm      = 1'b1;
    hold_off_req = 1'b1;
    for (k = 0; k < BurstLen; k++) begin
      next_random_date(a, b, c);
      send_date(a, b, c, 1'b0, none);
    end
    wait_drained();

    // Random dates, switching idle patterns every hundred requests
    for (k = 0; k < RandomDates; k++) begin
      if (k % 100 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      next_random_date(a, b, c);
      send_date(a, b, c, 1'b0, none);
    end
    wait_drained();

    $display("converted %0d dates (%0d in ISO order, %0d with a bad month), %0d results checked",
             dates_sent, iso_dates, error_dates, results_checked);
    $display("included a full-pipeline stall and a drain pause; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
